FILE: rtl/core/frwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwt_pkg
// Shared types for the fractional rank block: sequencer states and the
// control word broadcast to every cell of the ranking chain.
// ----------------------------------------------------------------------------
package frwt_pkg;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RANK,
		ST_EMIT
	} state_t;

	// Control word broadcast to all cells.
	typedef struct packed {
		logic start;   // set closes: arm the circulating copies
		logic rotate;  // compare against the circulating key, then advance the ring
		logic shift;   // move ranks one cell toward the output
	} cell_ctl_t;

endpackage : frwt_pkg
`default_nettype wire

FILE: rtl/core/frwt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frwt_cell
// One ranking cell: holds one key, a circulating copy of some key in the
// ring, and the running half-unit rank of its own key.
// ----------------------------------------------------------------------------
module frwt_cell #(
	parameter int KEY_BITS = 32,
	parameter int RANK_W   = 8
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  frwt_pkg::cell_ctl_t           ctl,
	input  wire                           wr,
	input  wire                           occ,
	input  wire logic signed [KEY_BITS-1:0] key_d,
	input  wire logic signed [KEY_BITS-1:0] trav_d,
	input  wire                           trav_vld_d,
	input  wire        [RANK_W-1:0]       rank_d,
	output logic signed [KEY_BITS-1:0]    trav,
	output logic                          trav_vld,
	output logic       [RANK_W-1:0]       rank
);
	import frwt_pkg::*;

	logic signed [KEY_BITS-1:0] key_q;
	logic signed [KEY_BITS-1:0] trav_q;
	logic                       tvld_q;
	logic [RANK_W-1:0]          rank_q;
	logic [RANK_W-1:0]          rank_inc;

	// Less counts two half units, equal counts one.
	always_comb begin
		rank_inc = '0;
		if (tvld_q) begin
			if (trav_q < key_q) begin
				rank_inc = RANK_W'(2);
			end else if (trav_q == key_q) begin
				rank_inc = RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvld_q <= 1'b0;
		end else if (ctl.start) begin
			tvld_q <= occ;
		end else if (ctl.rotate) begin
			tvld_q <= trav_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			key_q  <= key_d;
			trav_q <= key_d;
			rank_q <= RANK_W'(1);
		end else if (ctl.rotate) begin
			trav_q <= trav_d;
			rank_q <= rank_q + rank_inc;
		end else if (ctl.shift) begin
			rank_q <= rank_d;
		end
	end

	assign trav     = trav_q;
	assign trav_vld = tvld_q;
	assign rank     = rank_q;

endmodule : frwt_cell
`default_nettype wire

FILE: rtl/core/fractional_rank_with_ties.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fractional_rank_with_ties
// Ascending fractional ranking with averaged ties, in half units, over a set
// of signed keys loaded one beat at a time and closed by final_item.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   in      | to block  | in_valid/in_ready  | fitness_key[31:0], final_item
//   out     | from block| out_valid/out_ready| rank_halves[7:0], last_rank
//
// Loading takes one beat per cycle. The beat with final_item set starts a
// ranking pass, in which the key ring rotates once around all MAX_ITEMS
// cells. Ranks then leave one beat per cycle while out_ready is high, in
// input order, shifted out of cell 0.
// in_ready is low during the ranking pass and emission; out_ready low holds
// the current rank. Reset clears the sequencer, the count and the cells'
// valid flags; keys need no clearing pass.
// ----------------------------------------------------------------------------
module fractional_rank_with_ties #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_BITS  = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire logic signed [31:0] fitness_key,
	input  wire                final_item,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [7:0]         rank_halves,
	output logic               last_rank
);
	import frwt_pkg::*;

	// Ranks reach 2*MAX_ITEMS; the count reaches MAX_ITEMS.
	localparam int RANK_W = $clog2(2 * MAX_ITEMS + 1);
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int STEP_W = $clog2(MAX_ITEMS);

	state_t state_q, state_nx;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nx;
	logic [STEP_W-1:0] step_q;
	logic              in_fire;
	logic              out_fire;
	logic              not_full;
	logic              rank_done;
	cell_ctl_t         ctl;

	logic signed [KEY_BITS-1:0] key_in;
	logic signed [KEY_BITS-1:0] trav     [MAX_ITEMS];
	logic                       trav_vld [MAX_ITEMS];
	logic [RANK_W-1:0]          rank     [MAX_ITEMS];

	// Sign-extend or cut the key to the stored width.
	assign key_in = KEY_BITS'(fitness_key);

	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign not_full  = (count_q != CNT_W'(MAX_ITEMS));
	assign rank_done = (step_q == STEP_W'(MAX_ITEMS - 1));

	// Keys beyond a full store are dropped but still count toward closing.
	assign count_nx = not_full ? count_q + CNT_W'(1) : count_q;

	// Next state.
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_fire && final_item) begin
					state_nx = ST_RANK;
				end
			end
			ST_RANK: begin
				if (rank_done) begin
					state_nx = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_fire && last_rank) begin
					state_nx = ST_LOAD;
				end
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	// Outputs and cell control. in_ready is high throughout loading and
	// out_valid throughout emission, so the other side's signal decides.
	always_comb begin
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		ctl        = '0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready  = 1'b1;
				ctl.start = in_valid && final_item;
			end
			ST_RANK: begin
				ctl.rotate = 1'b1;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				ctl.shift = out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (in_fire) begin
				count_q <= count_nx;
			end else if (out_fire) begin
				// Count down the ranks still to deliver.
				count_q <= count_q - CNT_W'(1);
			end
			if (ctl.start) begin
				step_q <= '0;
			end else if (ctl.rotate) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	// Row of cells: a ring for the circulating keys, a line toward cell 0
	// for the ranks.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		localparam int PREV = (i == 0) ? MAX_ITEMS - 1 : i - 1;
		logic              wr_i;
		logic              occ_i;
		logic [RANK_W-1:0] rank_next;

		assign wr_i  = in_fire && not_full && (count_q == CNT_W'(i));
		assign occ_i = (CNT_W'(i) < count_nx);

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign rank_next = '0;
		end else begin : g_body
			assign rank_next = rank[i+1];
		end

		frwt_cell #(
			.KEY_BITS (KEY_BITS),
			.RANK_W   (RANK_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.wr         (wr_i),
			.occ        (occ_i),
			.key_d      (key_in),
			.trav_d     (trav[PREV]),
			.trav_vld_d (trav_vld[PREV]),
			.rank_d     (rank_next),
			.trav       (trav[i]),
			.trav_vld   (trav_vld[i]),
			.rank       (rank[i])
		);
	end

	assign rank_halves = 8'(rank[0]);
	assign last_rank   = (count_q == CNT_W'(1));

	// Load and emission never overlap.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	// The store never overfills.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ITEMS))
		else $error("item count beyond store depth");

	// Emission always has something left to deliver.
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_q != '0))
		else $error("rank beat with empty set");

	// Every delivered rank counts at least the key itself.
	a_rank_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rank_halves >= 8'd2))
		else $error("rank below minimum");

	// After the last beat, a fresh set begins.
	a_set_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_rank) |=> (count_q == '0 && in_ready))
		else $error("set not restarted after last rank");

endmodule : fractional_rank_with_ties
`default_nettype wire

FILE: tb/sv/fractional_rank_with_ties_test.sv
// ----------------------------------------------------------------------------
// fractional_rank_with_ties_test
// Self-checking bench for the averaged-tie fractional ranker. Sets of signed
// keys are streamed in bursts, and each closed set is ranked by a local
// predictor. Every rank beat that leaves the block is compared with the
// oldest prediction while the output side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module fractional_rank_with_ties_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ITEMS   = 64;
	localparam int KEY_TARGET  = 320;   // rough size of the random part, in key beats
	localparam int LONG_HOLD   = 300;   // cycles of receiver hold-off for the pressure case
	localparam int HOLD_AFTER  = 150;   // rank beats seen before that hold-off starts
	localparam int DRAIN_WAIT  = 3 * MAX_ITEMS;

	typedef struct {
		logic signed [31:0] key;
		logic               last;
	} key_beat_t;

	typedef struct {
		logic [7:0] halves;
		logic       last;
	} rank_beat_t;

	typedef enum int {
		RX_FREE,
		RX_HALF,
		RX_SPARSE
	} rx_mode_t;

	typedef enum int {
		KEY_ANY,
		KEY_NEAR_ZERO,
		KEY_EXTREME
	} key_kind_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] fitness_key = '0;
	logic               final_item = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         rank_halves;
	logic               last_rank;

	key_beat_t          key_beats[$];      // keys waiting to be offered
	logic signed [31:0] held_keys[$];      // predictor's copy of the open set
	rank_beat_t         expected_ranks[$]; // predicted ranks, oldest first

	int errors       = 0;
	int sets_closed  = 0;
	int sets_full    = 0;
	int keys_taken   = 0;
	int ranks_seen   = 0;

	fractional_rank_with_ties #(
		.MAX_ITEMS(MAX_ITEMS),
		.KEY_BITS (32)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.fitness_key(fitness_key),
		.final_item (final_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rank_halves(rank_halves),
		.last_rank  (last_rank)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor: store up to MAX_ITEMS keys, then on the closing beat rank the
	// whole set. Half-unit rank is 2*smaller + equal (self included) + 1.
	// Keys past capacity are dropped, but a dropped closing beat still ranks.
	// ------------------------------------------------------------------------
	task automatic absorb_key(input logic signed [31:0] key, input logic last);
		int         smaller;
		int         equal;
		rank_beat_t r;
		if (held_keys.size() < MAX_ITEMS)
			held_keys.push_back(key);
		if (last) begin
			if (held_keys.size() == MAX_ITEMS)
				sets_full++;
			foreach (held_keys[k]) begin
				smaller = 0;
				equal = 0;
				foreach (held_keys[m]) begin
					if (held_keys[m] < held_keys[k])
						smaller++;
					else if (held_keys[m] == held_keys[k])
						equal++;
				end
				r.halves = 8'(2 * smaller + equal + 1);
				r.last = (k == held_keys.size() - 1);
				expected_ranks.push_back(r);
			end
			held_keys.delete();
			sets_closed++;
		end
	endtask

	task automatic queue_key(input logic signed [31:0] key, input logic last);
		key_beat_t b;
		b.key = key;
		b.last = last;
		key_beats.push_back(b);
	endtask

	// Mix full-range keys with a narrow band around zero (so ties are common)
	// and fixed values: the two ends of the signed range, zero and -1.
	function automatic logic signed [31:0] pick_key();
		key_kind_t kind;
		int        roll;
		roll = $urandom_range(0, 9);
		kind = (roll < 4) ? KEY_ANY : (roll < 8) ? KEY_NEAR_ZERO : KEY_EXTREME;
		case (kind)
			KEY_ANY:       return $urandom;
			KEY_NEAR_ZERO: return $signed($urandom_range(0, 8)) - 4;
			default: begin
				case ($urandom_range(0, 3))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7FFF_FFFF;
					2:       return 32'sh0000_0000;
					default: return -32'sd1;
				endcase
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Sender: bursts of random length separated by random gaps. Advance only
	// when the current beat is taken or the slot is empty; otherwise hold.
	// ------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		key_beat_t b;
		if (arst_n && (!in_valid || in_ready)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (key_beats.size() > 0) begin
				b = key_beats.pop_front();
				in_valid <= 1'b1;
				fitness_key <= b.key;
				final_item <= b.last;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					// about a third of the bursts run straight into the next one
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: switch at random times between free-running, half-rate and
	// sparse acceptance. Once, after enough rank beats, hold off for a long
	// stretch so the block fills and backs up its input.
	// ------------------------------------------------------------------------
	rx_mode_t rx_mode   = RX_FREE;
	int       mode_left = 0;
	int       hold_left = 0;
	int       rx_beats  = 0;
	bit       hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				rx_beats <= rx_beats + 1;
			if (!hold_done && rx_beats >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= (hold_left == 1);
			end else begin
				if (mode_left == 0) begin
					rx_mode <= rx_mode_t'($urandom_range(0, 2));
					mode_left <= $urandom_range(5, 60);
				end else begin
					mode_left <= mode_left - 1;
				end
				case (rx_mode)
					RX_FREE:  out_ready <= 1'b1;
					RX_HALF:  out_ready <= 1'($urandom_range(0, 1));
					default:  out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: feed accepted key beats to the predictor, check every rank beat
	// against the oldest prediction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rank_beat_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				keys_taken++;
				absorb_key(fitness_key, final_item);
			end
			if (out_valid && out_ready) begin
				ranks_seen++;
				if (expected_ranks.size() == 0) begin
					$error("unexpected rank beat: rank_halves %0d, last_rank %0b",
						rank_halves, last_rank);
					errors++;
				end else begin
					want = expected_ranks.pop_front();
					if (rank_halves !== want.halves) begin
						$error("rank_halves: expected %0d, actual %0d",
							want.halves, rank_halves);
						errors++;
					end
					if (last_rank !== want.last) begin
						$error("last_rank: expected %0b, actual %0b",
							want.last, last_rank);
						errors++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------------
	initial begin
		int queued;
		int set_len;
		bit first_set;

		// Directed: a lone key ranks 2 and closes the set.
		queue_key(32'sh7FFF_FFFF, 1'b1);
		// Both ends of the signed range.
		queue_key(32'sh8000_0000, 1'b0);
		queue_key(32'sh7FFF_FFFF, 1'b1);
		// Every key tied: each gets the mean rank.
		repeat (5) queue_key(32'sh0001_8000, 1'b0);
		queue_key(32'sh0001_8000, 1'b1);
		// Mixed ties across the sign boundary.
		queue_key(-32'sd1, 1'b0);
		queue_key(32'sd0, 1'b0);
		queue_key(-32'sd1, 1'b0);
		queue_key(32'sd1, 1'b0);
		queue_key(32'sd0, 1'b0);
		queue_key(32'sh8000_0000, 1'b0);
		queue_key(32'sh7FFF_FFFF, 1'b1);
		// Descending run: input order differs from rank order.
		queue_key(32'sd300, 1'b0);
		queue_key(32'sd200, 1'b0);
		queue_key(32'sd100, 1'b0);
		queue_key(-32'sd100, 1'b1);

		// Random sets, mostly short. The first one overruns the store so the
		// closing beat is dropped yet still starts ranking; later ones may also
		// reach capacity.
		queued = 0;
		first_set = 1'b1;
		while (queued < KEY_TARGET) begin
			if (first_set)
				set_len = MAX_ITEMS + 2;
			else if ($urandom_range(0, 11) == 0)
				set_len = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
			else
				set_len = $urandom_range(1, 12);
			first_set = 1'b0;
			for (int i = 0; i < set_len; i++)
				queue_key(pick_key(), i == set_len - 1);
			queued += set_len;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (key_beats.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_ranks.size() != 0)
			@(negedge clk);
		// Let any stray beat show up before closing out.
		repeat (DRAIN_WAIT) @(negedge clk);

		$display("Run covered %0d key beats in %0d sets, %0d of them at store capacity.",
			keys_taken, sets_closed, sets_full);
		$display("%0d rank beats checked, %0d mismatches.", ranks_seen, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/frwt_pkg.sv
rtl/core/frwt_cell.sv
rtl/core/fractional_rank_with_ties.sv
tb/sv/fractional_rank_with_ties_test.sv
